@@ src/assert_macros.svh @@
// Assertion macros shared by the refraction block.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

@@ src/vr3d_pkg.sv @@
// Types, widths and helpers for the 3D refraction block.
// Depends on nothing; imported by every module of the block.
package vr3d_pkg;
   localparam int CompW  = 16;
   localparam int OutW   = 20;
   localparam int Lanes  = 3;
   localparam int Depth  = 37;  // pipeline stages from input to output register
   localparam int SqrtSteps = 30; // result bits of the root of a 60-bit value

   typedef logic signed [CompW-1:0] comp_type;
   typedef logic signed [OutW-1:0]  out_type;

   // Values that travel alongside the pipeline and go to the output lanes.
   typedef struct packed {
      logic                   tir;
      logic signed [33:0]     m14;
      logic [CompW-1:0]       eta;
   } scale_type;

   // Round half up at 2^14: add half, arithmetic shift.
   function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x + 64'sd8192;
      return y >>> 14;
   endfunction
endpackage

@@ src/vr3d_lane.sv @@
// One output lane: rnd(eta*I - m*N, 14) with saturation; zero on reflection.
// Depends on vr3d_pkg.
module vr3d_lane (
   input  logic                clock,
   input  logic                advance,
   input  vr3d_pkg::comp_type  incident,
   input  vr3d_pkg::comp_type  normal,
   input  vr3d_pkg::scale_type scale,
   output vr3d_pkg::out_type   refracted
);
   import vr3d_pkg::*;

   logic signed [32:0] ei_ff, ei_in;
   logic signed [50:0] mn_ff, mn_in;
   logic               tir_ff;
   logic signed [63:0] diff;
   logic signed [63:0] rounded;
   out_type            res_ff, res_in;

   // first stage: two products
   always_comb begin
      ei_in = 33'(signed'({1'b0, scale.eta}) * 33'(incident));
      mn_in = 51'(scale.m14 * 51'(normal));
   end

   always_comb begin
      diff    = 64'(ei_ff) - 64'(mn_ff);
      rounded = rnd14(diff);
      if (tir_ff) begin
         res_in = '0;
      end else if (rounded > 64'sd524287) begin
         res_in = 20'sh7FFFF;
      end else if (rounded < -64'sd524288) begin
         res_in = 20'sh80000;
      end else begin
         res_in = rounded[OutW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ei_ff  <= ei_in;
         mn_ff  <= mn_in;
         tir_ff <= scale.tir;
         res_ff <= res_in;
      end
   end

   assign refracted = res_ff;
endmodule

@@ src/vr3d_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on vr3d_pkg.
module vr3d_sqrt (
   input  logic        clock,
   input  logic        advance,
   input  logic [59:0] radicand,
   output logic [29:0] root
);
   import vr3d_pkg::*;

   logic [61:0] rem_ff [SqrtSteps];
   logic [29:0] res_ff [SqrtSteps];
   logic [59:0] val_ff [SqrtSteps];

   // restoring digit step: bring in two bits, try 4r+1
   for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
      logic [61:0] rem_prev;
      logic [29:0] res_prev;
      logic [59:0] val_prev;
      logic [61:0] rem_in;
      logic [61:0] trial;
      logic [29:0] res_in;
      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign res_prev = '0;
         assign val_prev = radicand;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign res_prev = res_ff[s-1];
         assign val_prev = val_ff[s-1];
      end
      always_comb begin
         rem_in = {rem_prev[59:0], val_prev[59:58]};
         trial  = 62'({res_prev, 2'b01});
         res_in = {res_prev[28:0], 1'b0};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            res_in[0] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in;
            res_ff[s] <= res_in;
            val_ff[s] <= {val_prev[57:0], 2'b00};
         end
      end
   end

   assign root = res_ff[SqrtSteps-1];
endmodule

@@ src/vr3d_core.sv @@
// Shared scalar path: dot product, k, square root and scale factor m.
// Depends on vr3d_pkg and vr3d_sqrt.
module vr3d_core (
   input  logic                clock,
   input  logic                advance,
   input  vr3d_pkg::comp_type  ix, iy, iz, nx, ny, nz,
   input  logic [15:0]         eta,
   output vr3d_pkg::scale_type scale
);
   import vr3d_pkg::*;

   // stage 1: lane products
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [31:0]        ee_ff;
   logic [15:0]        eta1_ff;
   // stage 2: c14, e14
   logic signed [19:0] c14_ff;
   logic [17:0]        e14_ff;
   logic [15:0]        eta2_ff;
   // stage 3: one_minus, eta*c
   logic signed [41:0] om_ff;
   logic signed [37:0] ec_ff;
   logic [17:0]        e14b_ff;
   logic [15:0]        eta3_ff;
   // stage 4: k42
   logic signed [63:0] k42_ff;
   logic signed [37:0] ec4_ff;
   logic [15:0]        eta4_ff;
   logic signed [63:0] rx;
   logic signed [63:0] k28;
   logic [59:0]        rad;
   logic [29:0]        root;
   logic signed [33:0] ecr;

   // delay line for values waiting on the square root
   logic signed [33:0] ecd_ff [SqrtSteps];
   logic               tird_ff [SqrtSteps];
   logic [15:0]        etad_ff [SqrtSteps];
   scale_type          scale_ff;

   always_comb begin
      rx  = rnd14(k42_ff);
      k28 = rx;
      rad = k42_ff[63] ? '0 : k28[59:0];
      ecr = 34'(rnd14(64'(ec4_ff)));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff   <= 32'(ix) * 32'(nx);
         py_ff   <= 32'(iy) * 32'(ny);
         pz_ff   <= 32'(iz) * 32'(nz);
         ee_ff   <= 32'(eta) * 32'(eta);
         eta1_ff <= eta;

         c14_ff  <= 20'(rnd14(64'(px_ff) + 64'(py_ff) + 64'(pz_ff)));
         e14_ff  <= 18'(rnd14(64'({32'd0, ee_ff})));
         eta2_ff <= eta1_ff;

         om_ff   <= 42'sd268435456 - 42'(c14_ff) * 42'(c14_ff);
         ec_ff   <= 38'(signed'({1'b0, eta2_ff}) * 38'(c14_ff));
         e14b_ff <= e14_ff;
         eta3_ff <= eta2_ff;

         k42_ff  <= (64'sd1 <<< 42) - 64'(signed'({1'b0, e14b_ff}) * 64'(om_ff));
         ec4_ff  <= ec_ff;
         eta4_ff <= eta3_ff;

         ecd_ff[0]  <= ecr;
         tird_ff[0] <= k42_ff[63];
         etad_ff[0] <= eta4_ff;
         for (int s = 1; s < SqrtSteps; s++) begin
            ecd_ff[s]  <= ecd_ff[s-1];
            tird_ff[s] <= tird_ff[s-1];
            etad_ff[s] <= etad_ff[s-1];
         end

         scale_ff.tir <= tird_ff[SqrtSteps-1];
         scale_ff.m14 <= ecd_ff[SqrtSteps-1] + 34'(root);
         scale_ff.eta <= etad_ff[SqrtSteps-1];
      end
   end

   vr3d_sqrt u_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (rad),
      .root     (root)
   );

   assign scale = scale_ff;
endmodule

@@ src/vector_refract_3d_top.sv @@
// Top level of the 3D refraction block: handshake, pipeline control, lanes.
// Depends on vr3d_pkg, vr3d_core, vr3d_lane and assert_macros.svh.
// Use:
//   req_ carries one ray per word: I, N and eta in req_tdata.
//   rsp_ returns the refracted vector in rsp_tdata and the total
//   reflection flag in rsp_tuser.
//   From acceptance to rsp_tvalid a ray passes the dot product and k stages,
//   the one-bit-per-stage square root, the scale factor m register and the
//   stages of each output lane (products, then the rounded and saturated
//   result register). Throughput is one word per cycle unless the receiver
//   stalls; the pipeline as a whole advances.
//   When the receiver stalls, hold the whole pipeline: req_tready drops
//   only while rsp_tvalid is high and rsp_tready low.
//   Reset clears the valid bits of every stage; data registers are not reset.
//   The three lanes form eta*I - m*N per component and saturate to Q5.14;
//   on total internal reflection they emit zero.
`include "assert_macros.svh"
module vector_refract_3d_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, eta
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // refracted_x, refracted_y, refracted_z, 4 zero bits
   output logic [63:0]  rsp_tdata,
   // total_reflection
   output logic         rsp_tuser
);
   import vr3d_pkg::*;

   logic              advance;
   logic [Depth-1:0]  vld_ff, vld_in;
   comp_type          incv [Lanes];
   comp_type          norv [Lanes];
   comp_type          incd_ff [Lanes][Depth-2];
   comp_type          nord_ff [Lanes][Depth-2];
   out_type           refr [Lanes];
   scale_type         scale;
   logic              tir_ff [2];

   // Advance every stage together; freeze the lot while the result waits.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[Depth-1];

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar l = 0; l < Lanes; l++) begin : g_unpack
      assign incv[l] = req_tdata[16*l +: 16];
      assign norv[l] = req_tdata[48 + 16*l +: 16];
   end

   // Delay I and N until the scale factor for the same ray is ready.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < Lanes; l++) begin
            incd_ff[l][0] <= incv[l];
            nord_ff[l][0] <= norv[l];
            for (int d = 1; d < Depth-2; d++) begin
               incd_ff[l][d] <= incd_ff[l][d-1];
               nord_ff[l][d] <= nord_ff[l][d-1];
            end
         end
      end
   end

   vr3d_core u_core (
      .clock   (clock),
      .advance (advance),
      .ix      (incv[0]), .iy (incv[1]), .iz (incv[2]),
      .nx      (norv[0]), .ny (norv[1]), .nz (norv[2]),
      .eta     (req_tdata[111:96]),
      .scale   (scale)
   );

   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      vr3d_lane u_lane (
         .clock     (clock),
         .advance   (advance),
         .incident  (incd_ff[l][Depth-3]),
         .normal    (nord_ff[l][Depth-3]),
         .scale     (scale),
         .refracted (refr[l])
      );
   end

   // Carry the reflection flag alongside the two lane stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         tir_ff[0] <= scale.tir;
         tir_ff[1] <= tir_ff[0];
      end
   end

   assign rsp_tdata = {4'b0000, refr[2], refr[1], refr[0]};
   assign rsp_tuser = tir_ff[1];

   `ASSERT_IMPLY(a_hold_on_stall, clock, reset, rsp_tvalid && !rsp_tready,
      !req_tready, "input accepted while output stalled")
   `ASSERT_NEXT(a_out_held, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `ASSERT_IMPLY(a_tir_zero, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[59:0] == 60'd0, "reflection with non-zero vector")
endmodule

@@ verif/testbench.sv @@
// Self-checking bench for the 3D refraction block: random and directed rays,
// predicted in fixed point and compared per word; uses vr3d_pkg and the top.
`timescale 1ns / 1ps

class refract_scoreboard;
   logic [63:0] pending[$];
   int errors;
   int shown;

   function automatic logic signed [63:0] half_up(input logic signed [63:0] x);
      return (x + 64'sd8192) >>> 14;
   endfunction

   function automatic logic [19:0] clamp_q514(input logic signed [63:0] v);
      if (v > 64'sd524287) return 20'h7FFFF;
      if (v < -64'sd524288) return 20'h80000;
      return v[19:0];
   endfunction

   // Work out the refracted vector for one ray and queue it.
   function void note_ray(input logic [111:0] ray);
      logic signed [63:0] inc[3], nrm[3];
      logic signed [63:0] eta, dot, c14, one_minus, e14, k42, k28, m14;
      logic [63:0] root, rem, bitv;
      logic [63:0] word;
      int i;
      eta = {48'd0, ray[111:96]};
      dot = 0;
      for (i = 0; i < 3; i++) begin
         inc[i] = {{48{ray[16*i+15]}}, ray[16*i +: 16]};
         nrm[i] = {{48{ray[16*i+63]}}, ray[16*i+48 +: 16]};
         dot += inc[i] * nrm[i];
      end
      c14 = half_up(dot);
      one_minus = (64'sd1 <<< 28) - c14 * c14;
      e14 = half_up(eta * eta);
      k42 = (64'sd1 <<< 42) - e14 * one_minus;
      word = '0;
      if (k42 < 0) begin
         word[60] = 1'b1;
      end else begin
         k28 = half_up(k42);
         rem = k28;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > rem) bitv >>= 2;
         while (bitv != 0) begin
            if (rem >= root + bitv) begin
               rem -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         m14 = half_up(eta * c14) + $signed(root);
         for (i = 0; i < 3; i++)
            word[20*i +: 20] = clamp_q514(half_up(eta * inc[i] - m14 * nrm[i]));
      end
      pending.push_back(word);
   endfunction

   // Compare one received word and its flag with the oldest prediction.
   function void check_word(input logic [63:0] got, input logic got_tir);
      logic [63:0] want;
      if (pending.size() == 0) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("unexpected result word %h tir=%b", got, got_tir);
         end
         return;
      end
      want = pending.pop_front();
      if (got[59:0] !== want[59:0] || got_tir !== want[60] || got[63:60] !== 4'b0000) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("mismatch: expected x=%h y=%h z=%h tir=%b, got x=%h y=%h z=%h tir=%b",
                     want[19:0], want[39:20], want[59:40], want[60],
                     got[19:0], got[39:20], got[59:40], got_tir);
         end
      end
   endfunction
endclass

module testbench;
   import vr3d_pkg::*;

   localparam int WatchLimit = 20000;
   localparam int RandomRays = 1180;
   localparam logic [15:0] One = 16'h4000; // 1.0 in Q1.14 / Q2.14

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;

   refract_scoreboard rays = new();
   int send_idle_pct = 0;   // chance per cycle that the sender idles
   int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
   bit hold_off = 1'b0;     // long receiver stall to fill the pipeline
   bit finished = 1'b0;
   int quiet = 0;

   vector_refract_3d_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: drive tready for the next edge, check any accepted word.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) rays.check_word(rsp_tdata, rsp_tuser);
      rsp_tready <= !reset && !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: count cycles with no word moving on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else if (!reset && !finished) quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
         $display("[vector_refract_3d_top] ERROR");
         $finish;
      end
   end

   // Offer one ray, idling at random first, and hold it until accepted.
   task automatic send_ray(input logic [111:0] ray);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ray;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rays.note_ray(ray);
   endtask

   // Wait for the pipeline to drain; the sender stays idle meanwhile.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (rays.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return $urandom_range(1) ? One : -One;
         default: return 16'($urandom());
      endcase
   endfunction

   // Mostly components within +/-1.0 and sensible eta, with some raw patterns.
   function automatic logic [111:0] random_ray();
      logic [15:0] f[7];
      int i;
      if ($urandom_range(3) == 0) begin
         for (i = 0; i < 6; i++) f[i] = pick_comp();
         f[6] = $urandom_range(2) == 0 ? 16'hFFFF : 16'($urandom());
      end else begin
         for (i = 0; i < 6; i++) f[i] = $signed(16'($urandom_range(32768))) - 16'sd16384;
         f[6] = 16'($urandom_range(8192, 40000));
      end
      return {f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   initial begin
      int p, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: straight through, grazing, reflection and range extremes.
      send_ray({One, One, 16'h0, 16'h0, -One, 16'h0, 16'h0});
      send_ray({16'h6000, One, 16'h0, 16'h0, 16'hE000, 16'h0, 16'h3800});
      send_ray({16'h8000, One, 16'h0, 16'h0, 16'h3F00, 16'h0, 16'h0800}); // eta 2.0, refracts without reflection
      send_ray({16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      send_ray({16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
      send_ray({16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      send_ray({16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000});
      send_ray({16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
      send_ray({One, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h7FFF, 16'h8000});
      send_ray({16'h8000, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      send_ray({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
      send_ray({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
      drain();

      // Pause the receiver long enough for the pipeline to fill and stall.
      hold_off = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         for (n = 0; n < 60; n++) send_ray(random_ray());
      join
      drain();

      // Random phases: none, sender idle, receiver stall, both.
      for (p = 0; p < 4; p++) begin
         send_idle_pct  = (p == 1) ? 50 : (p == 3) ? 26 : 0;
         recv_stall_pct = (p == 2) ? 50 : (p == 3) ? 26 : 0;
         for (n = 0; n < RandomRays / 4; n++) send_ray(random_ray());
         drain();
      end

      repeat (60) @(posedge clock);
      finished = 1'b1;
      if (rays.errors == 0 && rays.pending.size() == 0)
         $display("[vector_refract_3d_top] OK");
      else
         $display("[vector_refract_3d_top] ERROR");
      $finish;
   end
endmodule
